/* sv/segint_pkg.sv */
// Shared types and defaults for the segment intersection tester.
// No dependencies; imported by the divider cell and the top level.
`default_nettype none

package segint_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Control that travels with an item down the divider chain.
    typedef struct packed {
        logic valid;
        logic hit;
        logic coll;
        logic div;
        logic neg_x;
        logic neg_y;
    } segint_ctl_t;

endpackage

`default_nettype wire

/* sv/segint_div_cell.sv */
// One restoring-division cell: settles one quotient bit for x and y lanes.
// Depends on segint_pkg for the control struct.
`default_nettype none

module segint_div_cell #(
    parameter int W     = 41,
    parameter int QB    = 12,
    parameter int SHIFT = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire segint_pkg::segint_ctl_t     ctl_in,
    input  wire logic [W-1:0]                rem_x_in,
    input  wire logic [W-1:0]                rem_y_in,
    input  wire logic [W-1:0]                dv_in,
    input  wire logic [QB-1:0]               qx_in,
    input  wire logic [QB-1:0]               qy_in,
    output segint_pkg::segint_ctl_t          ctl_out,
    output logic [W-1:0]                     rem_x_out,
    output logic [W-1:0]                     rem_y_out,
    output logic [W-1:0]                     dv_out,
    output logic [QB-1:0]                    qx_out,
    output logic [QB-1:0]                    qy_out
);
    import segint_pkg::*;

    segint_ctl_t      ctl_reg;
    logic [W-1:0]     rem_x_reg, rem_x_next;
    logic [W-1:0]     rem_y_reg, rem_y_next;
    logic [W-1:0]     dv_reg;
    logic [QB-1:0]    qx_reg, qx_next;
    logic [QB-1:0]    qy_reg, qy_next;
    logic [W-1:0]     dsh;
    logic [QB-1:0]    qbit;

    always_comb
    begin
        dsh  = dv_in << SHIFT;
        qbit = QB'(1) << SHIFT;
        rem_x_next = rem_x_in;
        qx_next    = qx_in;
        if (rem_x_in >= dsh)
        begin
            rem_x_next = rem_x_in - dsh;
            qx_next    = qx_in | qbit;
        end
        rem_y_next = rem_y_in;
        qy_next    = qy_in;
        if (rem_y_in >= dsh)
        begin
            rem_y_next = rem_y_in - dsh;
            qy_next    = qy_in | qbit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        dv_reg    <= dv_in;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
    end

    assign ctl_out   = ctl_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign dv_out    = dv_reg;
    assign qx_out    = qx_reg;
    assign qy_out    = qy_reg;

endmodule

`default_nettype wire

/* sv/segment_intersection_tester_core.sv */
// Segment intersection tester: orientation test plus rounded meeting point.
// Pipeline: the input register loads at the accept edge, then four arithmetic
//   stages, one divider cell per quotient bit, output register.
//   Throughput: one item every cycle; busy is never raised.
// The receiver cannot stall; each result shows for one cycle with done high.
// Reset (rst_n low, async) empties the pipeline; no item is in flight after it.
// Depends on segint_pkg and segint_div_cell.
`default_nettype none

module segment_intersection_tester_core #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_BITS-1:0]  first_start_x,
    input  wire logic signed [COORD_BITS-1:0]  first_start_y,
    input  wire logic signed [COORD_BITS-1:0]  first_end_x,
    input  wire logic signed [COORD_BITS-1:0]  first_end_y,
    input  wire logic signed [COORD_BITS-1:0]  second_start_x,
    input  wire logic signed [COORD_BITS-1:0]  second_start_y,
    input  wire logic signed [COORD_BITS-1:0]  second_end_x,
    input  wire logic signed [COORD_BITS-1:0]  second_end_y,
    output logic                               done,
    output logic                               hit,
    output logic signed [COORD_BITS-1:0]       meet_x,
    output logic signed [COORD_BITS-1:0]       meet_y,
    output logic                               collinear_overlap
);
    import segint_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;        // coordinate difference
    localparam int PW = 2 * C + 2;    // product of two differences
    localparam int OW = 2 * C + 3;    // orientation / determinant
    localparam int CW = 2 * C;        // product of two coordinates
    localparam int TW = 2 * C + 1;    // det1, det2
    localparam int MW = 3 * C + 2;    // det times difference
    localparam int NW = 3 * C + 3;    // Cramer numerator
    localparam int W  = 3 * C + 5;    // divider remainder

    function automatic logic in_box(
        input logic signed [C-1:0] ax, input logic signed [C-1:0] ay,
        input logic signed [C-1:0] bx, input logic signed [C-1:0] by,
        input logic signed [C-1:0] px, input logic signed [C-1:0] py
    );
        logic signed [C-1:0] lx, hx, ly, hy;
        lx = (ax < bx) ? ax : bx;
        hx = (ax > bx) ? ax : bx;
        ly = (ay < by) ? ay : by;
        hy = (ay > by) ? ay : by;
        return (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
    endfunction

    // ---------------- stage 0: input register ----------------
    logic                 accept;
    logic                 v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [C-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [C-1:0]  cx_reg, cy_reg, dx_reg, dy_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---------------- stage 1: differences and products ----------------
    logic signed [DW-1:0] axe, aye, bxe, bye, cxe, cye, dxe, dye;
    logic signed [DW-1:0] bax, bay, cax, cay, dax, day;
    logic signed [DW-1:0] dcx, dcy, acx, acy, bcx, bcy;
    logic signed [DW-1:0] ex_next, ey_next, fx_next, fy_next;
    logic signed [PW-1:0] prod_next [0:9];
    logic signed [CW-1:0] cprod_next [0:3];
    logic [3:0]           box_next;

    logic signed [PW-1:0] prod_reg [0:9];
    logic signed [CW-1:0] cprod_reg [0:3];
    logic [3:0]           box1_reg;
    logic signed [DW-1:0] ex1_reg, ey1_reg, fx1_reg, fy1_reg;

    always_comb
    begin
        axe = DW'(ax_reg); aye = DW'(ay_reg); bxe = DW'(bx_reg); bye = DW'(by_reg);
        cxe = DW'(cx_reg); cye = DW'(cy_reg); dxe = DW'(dx_reg); dye = DW'(dy_reg);
        bax = bxe - axe; bay = bye - aye;
        cax = cxe - axe; cay = cye - aye;
        dax = dxe - axe; day = dye - aye;
        dcx = dxe - cxe; dcy = dye - cye;
        acx = axe - cxe; acy = aye - cye;
        bcx = bxe - cxe; bcy = bye - cye;
        fx_next = axe - bxe; fy_next = aye - bye;
        ex_next = cxe - dxe; ey_next = cye - dye;
        // o1..o4 and the determinant, as pairs of products
        prod_next[0] = PW'(bax) * PW'(cay);
        prod_next[1] = PW'(bay) * PW'(cax);
        prod_next[2] = PW'(bax) * PW'(day);
        prod_next[3] = PW'(bay) * PW'(dax);
        prod_next[4] = PW'(dcx) * PW'(acy);
        prod_next[5] = PW'(dcy) * PW'(acx);
        prod_next[6] = PW'(dcx) * PW'(bcy);
        prod_next[7] = PW'(dcy) * PW'(bcx);
        prod_next[8] = PW'(fx_next) * PW'(ey_next);
        prod_next[9] = PW'(fy_next) * PW'(ex_next);
        cprod_next[0] = CW'(ax_reg) * CW'(by_reg);
        cprod_next[1] = CW'(ay_reg) * CW'(bx_reg);
        cprod_next[2] = CW'(cx_reg) * CW'(dy_reg);
        cprod_next[3] = CW'(cy_reg) * CW'(dx_reg);
        box_next[0] = in_box(ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg);
        box_next[1] = in_box(ax_reg, ay_reg, bx_reg, by_reg, dx_reg, dy_reg);
        box_next[2] = in_box(cx_reg, cy_reg, dx_reg, dy_reg, ax_reg, ay_reg);
        box_next[3] = in_box(cx_reg, cy_reg, dx_reg, dy_reg, bx_reg, by_reg);
    end

    // ---------------- stage 2: orientations, determinants ----------------
    logic signed [OW-1:0] ori_next [0:4];     // entry 4 is the determinant
    logic signed [TW-1:0] det1_next, det2_next;
    logic signed [OW-1:0] ori_reg [0:4];
    logic signed [TW-1:0] det1_reg, det2_reg;
    logic [3:0]           box2_reg;
    logic signed [DW-1:0] ex2_reg, ey2_reg, fx2_reg, fy2_reg;

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            ori_next[i] = OW'(prod_reg[2*i]) - OW'(prod_reg[2*i+1]);
        end
        det1_next = TW'(cprod_reg[0]) - TW'(cprod_reg[1]);
        det2_next = TW'(cprod_reg[2]) - TW'(cprod_reg[3]);
    end

    // ---------------- stage 3: hit decision, numerator products ----------------
    logic [3:0]           pos, negs, zer;
    logic                 hit_next, den_zero;
    logic signed [MW-1:0] m_next [0:3];
    logic signed [MW-1:0] m_reg [0:3];
    logic signed [OW-1:0] den3_reg;
    logic                 hit3_reg, coll3_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            zer[i]  = (ori_reg[i] == '0);
            negs[i] = ori_reg[i][OW-1];
            pos[i]  = !negs[i] && !zer[i];
        end
        // proper crossing: strict opposite sides on both segments, or a collinear endpoint inside the other box
        hit_next = (((pos[0] && negs[1]) || (negs[0] && pos[1])) &&
                    ((pos[2] && negs[3]) || (negs[2] && pos[3])))
                   || (zer[0] && box2_reg[0]) || (zer[1] && box2_reg[1])
                   || (zer[2] && box2_reg[2]) || (zer[3] && box2_reg[3]);
        den_zero = (ori_reg[4] == '0);
        m_next[0] = MW'(det1_reg) * MW'(ex2_reg);
        m_next[1] = MW'(det2_reg) * MW'(fx2_reg);
        m_next[2] = MW'(det1_reg) * MW'(ey2_reg);
        m_next[3] = MW'(det2_reg) * MW'(fy2_reg);
    end

    // ---------------- stage 4: divider operands ----------------
    // Rounded quotient = floor((2|n| + |d|) / (2|d|)), sign applied at the end.
    logic signed [NW-1:0] nx, ny;
    logic [NW-1:0]        magx, magy;
    logic [OW-1:0]        magd;
    logic [W-1:0]         numx_next, numy_next, dv_next;
    segint_ctl_t          ctl_next, ctl4_reg;
    logic [W-1:0]         numx_reg, numy_reg, dv_reg;

    always_comb
    begin
        nx   = NW'(m_reg[0]) - NW'(m_reg[1]);
        ny   = NW'(m_reg[2]) - NW'(m_reg[3]);
        magx = nx[NW-1] ? NW'(-nx) : NW'(nx);
        magy = ny[NW-1] ? NW'(-ny) : NW'(ny);
        magd = den3_reg[OW-1] ? OW'(-den3_reg) : OW'(den3_reg);
        numx_next = (W'(magx) << 1) + W'(magd);
        numy_next = (W'(magy) << 1) + W'(magd);
        dv_next   = W'(magd) << 1;
        ctl_next.valid = v3_reg;
        ctl_next.hit   = hit3_reg;
        ctl_next.coll  = coll3_reg;
        ctl_next.div   = hit3_reg && !coll3_reg;
        ctl_next.neg_x = nx[NW-1] ^ den3_reg[OW-1];
        ctl_next.neg_y = ny[NW-1] ^ den3_reg[OW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            ctl4_reg <= '0;
        end
        else
        begin
            v0_reg   <= accept;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            ctl4_reg <= ctl_next;
        end
    end

    assign v4_reg = ctl4_reg.valid;

    always_ff @(posedge clk)
    begin
        ax_reg <= first_start_x;  ay_reg <= first_start_y;
        bx_reg <= first_end_x;    by_reg <= first_end_y;
        cx_reg <= second_start_x; cy_reg <= second_start_y;
        dx_reg <= second_end_x;   dy_reg <= second_end_y;
        for (int i = 0; i < 10; i++)
        begin
            prod_reg[i] <= prod_next[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            cprod_reg[i] <= cprod_next[i];
            m_reg[i]     <= m_next[i];
        end
        box1_reg <= box_next;
        ex1_reg <= ex_next; ey1_reg <= ey_next; fx1_reg <= fx_next; fy1_reg <= fy_next;
        for (int i = 0; i < 5; i++)
        begin
            ori_reg[i] <= ori_next[i];
        end
        det1_reg <= det1_next;
        det2_reg <= det2_next;
        box2_reg <= box1_reg;
        ex2_reg <= ex1_reg; ey2_reg <= ey1_reg; fx2_reg <= fx1_reg; fy2_reg <= fy1_reg;
        den3_reg  <= ori_reg[4];
        hit3_reg  <= hit_next;
        coll3_reg <= hit_next && den_zero;
        numx_reg  <= numx_next;
        numy_reg  <= numy_next;
        dv_reg    <= dv_next;
    end

    // ---------------- divider chain: one cell per quotient bit, MSB first ----------------
    segint_ctl_t   ch_ctl [0:C];
    logic [W-1:0]  ch_rx  [0:C];
    logic [W-1:0]  ch_ry  [0:C];
    logic [W-1:0]  ch_dv  [0:C];
    logic [C-1:0]  ch_qx  [0:C];
    logic [C-1:0]  ch_qy  [0:C];

    assign ch_ctl[0] = ctl4_reg;
    assign ch_rx[0]  = numx_reg;
    assign ch_ry[0]  = numy_reg;
    assign ch_dv[0]  = dv_reg;
    assign ch_qx[0]  = '0;
    assign ch_qy[0]  = '0;

    for (genvar g = 0; g < C; g++)
    begin : g_cell
        segint_div_cell #(
            .W     (W),
            .QB    (C),
            .SHIFT (C - 1 - g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ch_ctl[g]),
            .rem_x_in  (ch_rx[g]),
            .rem_y_in  (ch_ry[g]),
            .dv_in     (ch_dv[g]),
            .qx_in     (ch_qx[g]),
            .qy_in     (ch_qy[g]),
            .ctl_out   (ch_ctl[g+1]),
            .rem_x_out (ch_rx[g+1]),
            .rem_y_out (ch_ry[g+1]),
            .dv_out    (ch_dv[g+1]),
            .qx_out    (ch_qx[g+1]),
            .qy_out    (ch_qy[g+1])
        );
    end

    // ---------------- output register ----------------
    segint_ctl_t          fin;
    logic [C-1:0]         mx_next, my_next;
    logic                 done_reg, hit_reg, coll_reg;
    logic signed [C-1:0]  mx_reg, my_reg;

    always_comb
    begin
        fin     = ch_ctl[C];
        mx_next = '0;
        my_next = '0;
        if (fin.div)
        begin
            mx_next = fin.neg_x ? C'(-ch_qx[C]) : ch_qx[C];
            my_next = fin.neg_y ? C'(-ch_qy[C]) : ch_qy[C];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= fin.hit;
        coll_reg <= fin.coll;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
    end

    assign done              = done_reg;
    assign hit               = hit_reg;
    assign collinear_overlap = coll_reg;
    assign meet_x            = mx_reg;
    assign meet_y            = my_reg;

    // ---------------- assertions ----------------
    a_coll_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!collinear_overlap || hit))
        else $error("collinear flag without hit");

    a_miss_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (!hit || collinear_overlap)) |-> (meet_x == '0 && meet_y == '0))
        else $error("nonzero point on miss or degenerate hit");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> ##(C+1) done)
        else $error("item lost in divider chain");

    a_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
        ctl4_reg.valid |-> (ctl4_reg.div == (ctl4_reg.hit && !ctl4_reg.coll)))
        else $error("divide flag inconsistent");

endmodule

`default_nettype wire
